// ----- rtl/core/bdll_pkg.sv -----
// Package for the bounded doubly linked list engine: sizes, op/status codes,
// sequencer states and the packed command/result types. No dependencies.
`default_nettype none
package bdll_pkg;
    localparam int Capacity = 256;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_INSERT     = 3'd4,
        OP_REMOVE     = 3'd5,
        OP_READ       = 3'd6,
        OP_NOP        = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DECODE,
        S_WALK,
        S_LINK_A,
        S_LINK_B,
        S_UNLINK,
        S_ENDS,
        S_ENDS_WAIT,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]         op;
        logic [CntW-1:0]    position;
        logic signed [31:0] value_in;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [CntW-1:0]    count;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [1:0]         status;
    } result_t;
endpackage
`default_nettype wire

// ----- rtl/core/bounded_doubly_linked_list.sv -----
// Bounded doubly linked list engine: one command in, one result out.
// Depends on bdll_pkg.
//
// A command is taken when start is high and busy is low; its result is on
// result for the single cycle that done is high and cannot be held off.
// After reset busy stays high while the free stack is filled. Insert,
// remove and read walk the next links from the head one memory read a
// cycle; a rejected request or a no-op skips the walk and the link steps.
// done is high in the last busy cycle and the next command can be taken in
// the cycle after it.
`default_nettype none
module bounded_doubly_linked_list (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire bdll_pkg::cmd_t   cmd,
    output logic                  busy,
    output logic                  done,
    output bdll_pkg::result_t     result
);
    localparam int IdxW = bdll_pkg::IdxW;
    localparam int CntW = bdll_pkg::CntW;

    // node store, links and free stack
    logic [31:0]     val_mem [bdll_pkg::Capacity];
    logic [IdxW-1:0] nxt_mem [bdll_pkg::Capacity];
    logic [IdxW-1:0] prv_mem [bdll_pkg::Capacity];
    logic [IdxW-1:0] free_mem[bdll_pkg::Capacity];

    bdll_pkg::state_t state_reg, state_next;
    bdll_pkg::cmd_t   cmd_reg;
    logic [CntW-1:0]  cnt_reg, free_cnt_reg, step_reg;
    logic [IdxW-1:0]  head_reg, tail_reg, node_reg, newn_reg, link_reg;
    logic [31:0]      vout_reg, front_reg;
    logic [1:0]       stat_reg;
    logic             mode_del_reg;     // walk ends in unlink (else link)

    // registered read ports
    logic [IdxW-1:0]  nxt_q, prv_q, free_q;
    logic [31:0]      val_q;
    logic [IdxW-1:0]  rd_addr;

    // write ports
    logic             nxt_we, prv_we, val_we, free_we;
    logic [IdxW-1:0]  nxt_wa, nxt_wd, prv_wa, prv_wd, free_wa, free_wd;

    logic [2:0] op_c;
    logic       full_c, empty_c, at_front_c, at_back_c;
    assign op_c    = cmd_reg.op;
    assign full_c  = cnt_reg == CntW'(bdll_pkg::Capacity);
    assign empty_c = cnt_reg == '0;
    // position zero prepends, position equal to count appends
    assign at_front_c = op_c == bdll_pkg::OP_PUSH_FRONT ||
                        (op_c == bdll_pkg::OP_INSERT && cmd_reg.position == '0);
    assign at_back_c  = op_c == bdll_pkg::OP_PUSH_BACK ||
                        (op_c == bdll_pkg::OP_INSERT && cmd_reg.position == cnt_reg
                         && cmd_reg.position != '0);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bdll_pkg::S_INIT:
                if (free_cnt_reg == CntW'(bdll_pkg::Capacity - 1))
                    state_next = bdll_pkg::S_IDLE;
            bdll_pkg::S_IDLE:
                if (start) state_next = bdll_pkg::S_DECODE;
            bdll_pkg::S_DECODE:
                state_next = bdll_pkg::S_WALK;
            bdll_pkg::S_WALK:
                if (stat_reg != bdll_pkg::ST_OK || op_c == bdll_pkg::OP_NOP)
                    state_next = bdll_pkg::S_ENDS;
                else if (step_reg == '0)
                    state_next = mode_del_reg ? bdll_pkg::S_UNLINK : bdll_pkg::S_LINK_A;
            bdll_pkg::S_LINK_A: state_next = bdll_pkg::S_LINK_B;
            bdll_pkg::S_LINK_B: state_next = bdll_pkg::S_ENDS;
            bdll_pkg::S_UNLINK: state_next = bdll_pkg::S_ENDS;
            bdll_pkg::S_ENDS:   state_next = bdll_pkg::S_ENDS_WAIT;
            bdll_pkg::S_ENDS_WAIT: state_next = bdll_pkg::S_DONE;
            bdll_pkg::S_DONE:   state_next = bdll_pkg::S_IDLE;
            default:            state_next = bdll_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = state_reg != bdll_pkg::S_IDLE;
        done = state_reg == bdll_pkg::S_DONE;
        result.value_out   = vout_reg;
        result.count       = cnt_reg;
        result.front_value = empty_c ? '0 : front_reg;
        // tail read issued in S_ENDS_WAIT lands in the done cycle
        result.back_value  = empty_c ? '0 : val_q;
        result.status      = stat_reg;

        // one read address for node value and both links
        case (state_reg)
            bdll_pkg::S_DECODE:
                rd_addr = (op_c == bdll_pkg::OP_POP_BACK) ? tail_reg : head_reg;
            bdll_pkg::S_WALK:
                rd_addr = (step_reg != '0) ? nxt_q : node_reg;
            bdll_pkg::S_ENDS:      rd_addr = head_reg;
            bdll_pkg::S_ENDS_WAIT: rd_addr = tail_reg;
            default:               rd_addr = node_reg;
        endcase

        nxt_we  = 1'b0;
        nxt_wa  = newn_reg;
        nxt_wd  = newn_reg;
        prv_we  = 1'b0;
        prv_wa  = newn_reg;
        prv_wd  = newn_reg;
        val_we  = 1'b0;
        free_we = 1'b0;
        free_wa = free_cnt_reg[IdxW-1:0];
        free_wd = node_reg;
        case (state_reg)
            bdll_pkg::S_INIT:
            begin
                // top of stack ends up as node 0
                free_we = 1'b1;
                free_wd = IdxW'(bdll_pkg::Capacity - 1) - free_cnt_reg[IdxW-1:0];
            end
            bdll_pkg::S_LINK_A:
                if (at_front_c)
                begin
                    nxt_we = 1'b1;
                    nxt_wd = empty_c ? newn_reg : head_reg;
                    prv_we = !empty_c;
                    prv_wa = head_reg;
                end
                else if (at_back_c)
                begin
                    prv_we = 1'b1;
                    prv_wd = empty_c ? newn_reg : tail_reg;
                    nxt_we = !empty_c;
                    nxt_wa = tail_reg;
                end
                else
                begin
                    // before node_reg: prv_q is its predecessor
                    nxt_we = 1'b1;
                    nxt_wa = prv_q;
                    prv_we = 1'b1;
                    prv_wa = node_reg;
                end
            bdll_pkg::S_LINK_B:
            begin
                val_we = 1'b1;
                if (at_front_c)
                    prv_we = 1'b1;
                else if (at_back_c)
                    nxt_we = 1'b1;
                else
                begin
                    prv_we = 1'b1;
                    prv_wd = link_reg;
                    nxt_we = 1'b1;
                    nxt_wd = node_reg;
                end
            end
            bdll_pkg::S_UNLINK:
                if (op_c != bdll_pkg::OP_READ)
                begin
                    free_we = 1'b1;
                    if (cnt_reg != CntW'(1) && node_reg != head_reg && node_reg != tail_reg)
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_q;
                        nxt_wd = nxt_q;
                        prv_we = 1'b1;
                        prv_wa = nxt_q;
                        prv_wd = prv_q;
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        if (prv_we) prv_mem[prv_wa] <= prv_wd;
        if (val_we) val_mem[newn_reg] <= cmd_reg.value_in;
        if (free_we) free_mem[free_wa] <= free_wd;
        nxt_q  <= nxt_mem[rd_addr];
        prv_q  <= prv_mem[rd_addr];
        val_q  <= val_mem[rd_addr];
        free_q <= free_mem[free_cnt_reg[IdxW-1:0] - IdxW'(1)];
    end

    // Main sequencer datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bdll_pkg::S_INIT;
            free_cnt_reg <= '0;
            cnt_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            stat_reg     <= bdll_pkg::ST_OK;
            mode_del_reg <= 1'b0;
            step_reg     <= '0;
            node_reg     <= '0;
            newn_reg     <= '0;
            link_reg     <= '0;
            vout_reg     <= '0;
            front_reg    <= '0;
            cmd_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                bdll_pkg::S_INIT:
                    free_cnt_reg <= free_cnt_reg + CntW'(1);
                bdll_pkg::S_IDLE:
                    if (start) cmd_reg <= cmd;
                bdll_pkg::S_DECODE:
                begin
                    vout_reg     <= '0;
                    stat_reg     <= bdll_pkg::ST_OK;
                    node_reg     <= head_reg;
                    newn_reg     <= free_q;
                    mode_del_reg <= 1'b1;
                    step_reg     <= '0;
                    case (op_c)
                        bdll_pkg::OP_PUSH_FRONT, bdll_pkg::OP_PUSH_BACK:
                        begin
                            mode_del_reg <= 1'b0;
                            if (full_c) stat_reg <= bdll_pkg::ST_FULL;
                        end
                        bdll_pkg::OP_POP_FRONT, bdll_pkg::OP_POP_BACK:
                        begin
                            if (empty_c) stat_reg <= bdll_pkg::ST_EMPTY;
                            if (op_c == bdll_pkg::OP_POP_BACK) node_reg <= tail_reg;
                        end
                        bdll_pkg::OP_INSERT:
                        begin
                            mode_del_reg <= 1'b0;
                            if (full_c) stat_reg <= bdll_pkg::ST_FULL;
                            else if (cmd_reg.position > cnt_reg)
                                stat_reg <= bdll_pkg::ST_RANGE;
                            else if (cmd_reg.position != cnt_reg)
                                step_reg <= cmd_reg.position;
                        end
                        bdll_pkg::OP_REMOVE, bdll_pkg::OP_READ:
                        begin
                            if (empty_c) stat_reg <= bdll_pkg::ST_EMPTY;
                            else if (cmd_reg.position >= cnt_reg)
                                stat_reg <= bdll_pkg::ST_RANGE;
                            else step_reg <= cmd_reg.position;
                        end
                        default: ;
                    endcase
                end
                bdll_pkg::S_WALK:
                    // nxt_q holds the next link of node_reg; one link per cycle
                    if (stat_reg == bdll_pkg::ST_OK && step_reg != '0)
                    begin
                        step_reg <= step_reg - CntW'(1);
                        node_reg <= nxt_q;
                    end
                bdll_pkg::S_LINK_A:
                    link_reg <= prv_q;
                bdll_pkg::S_LINK_B:
                begin
                    free_cnt_reg <= free_cnt_reg - CntW'(1);
                    cnt_reg <= cnt_reg + CntW'(1);
                    if (at_front_c)
                    begin
                        head_reg <= newn_reg;
                        if (empty_c) tail_reg <= newn_reg;
                    end
                    else if (at_back_c)
                    begin
                        tail_reg <= newn_reg;
                        if (empty_c) head_reg <= newn_reg;
                    end
                end
                bdll_pkg::S_UNLINK:
                begin
                    vout_reg <= val_q;
                    if (op_c != bdll_pkg::OP_READ)
                    begin
                        cnt_reg <= cnt_reg - CntW'(1);
                        free_cnt_reg <= free_cnt_reg + CntW'(1);
                        if (cnt_reg == CntW'(1))
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end
                        else if (node_reg == head_reg)
                            head_reg <= nxt_q;
                        else if (node_reg == tail_reg)
                            tail_reg <= prv_q;
                    end
                end
                bdll_pkg::S_ENDS_WAIT:
                    front_reg <= val_q;
                default: ;
            endcase
        end
    end

    property p_done_one;
        @(posedge clk) disable iff (!rst_n) done |=> !done;
    endproperty
    assert property (p_done_one) else $error("done held two cycles");

    property p_count_bound;
        @(posedge clk) disable iff (!rst_n)
            state_reg == bdll_pkg::S_IDLE |-> cnt_reg <= CntW'(bdll_pkg::Capacity);
    endproperty
    assert property (p_count_bound) else $error("count above capacity");

    property p_free_sum;
        @(posedge clk) disable iff (!rst_n)
            state_reg == bdll_pkg::S_IDLE && $past(state_reg) == bdll_pkg::S_DONE
            |-> (cnt_reg + free_cnt_reg) == CntW'(bdll_pkg::Capacity);
    endproperty
    assert property (p_free_sum) else $error("free count and list count disagree");

    property p_start_ignored_busy;
        @(posedge clk) disable iff (!rst_n)
            busy && state_reg != bdll_pkg::S_DONE && state_reg != bdll_pkg::S_INIT
            |=> busy;
    endproperty
    assert property (p_start_ignored_busy) else $error("busy dropped mid command");
endmodule
`default_nettype wire
